FILE: hdl/tmf_pkg.sv
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared types and default sizes of the trimmed mean filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

	localparam int CHANNELS_DEF    = 8;
	localparam int WINDOW_DEF      = 5;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int CHAN_W  = 3;
	localparam int SMP_W   = 12;
	localparam int AVG_W   = 12;

	// decoupling queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [SMP_W-1:0]  sample;
	} tmf_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_channel;
		logic [AVG_W-1:0]  average;
	} tmf_out_t;

endpackage

FILE: hdl/tmf_front.sv
// ----------------------------------------------------------------------------
// tmf_front
// Input register: takes sample beats, drops those of channels that do not
// exist, and pushes the rest into the decoupling queue.
// ----------------------------------------------------------------------------
module tmf_front #(
	parameter int CHANNELS = tmf_pkg::CHANNELS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             smp_valid,
	output logic             smp_stall,
	input  tmf_pkg::tmf_in_t smp_data,
	output logic             push,
	output tmf_pkg::tmf_in_t push_data,
	input  logic             full
);
	import tmf_pkg::*;

	logic    vld_q;
	tmf_in_t item_q;
	logic    in_range;

	assign in_range  = (32'(smp_data.channel) < CHANNELS);
	assign smp_stall = vld_q && full;
	assign push      = vld_q && !full;
	assign push_data = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (!smp_stall) begin
			vld_q <= smp_valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (!smp_stall && smp_valid && in_range) begin
			item_q <= smp_data;
		end
	end

endmodule

FILE: hdl/tmf_queue.sv
// ----------------------------------------------------------------------------
// tmf_queue
// Short register FIFO that lets the front and the back stall on their own.
// ----------------------------------------------------------------------------
module tmf_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tmf_pkg::tmf_in_t push_data,
	input  logic             pop,
	output tmf_pkg::tmf_in_t pop_data,
	output logic             full,
	output logic             empty
);
	import tmf_pkg::*;

	tmf_in_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue popped while empty");
`endif

endmodule

FILE: hdl/tmf_back.sv
// ----------------------------------------------------------------------------
// tmf_back
// Per-channel accumulate (count, sum, min, max) and trimmed mean pipeline:
// state update at pop, trim subtract, reciprocal multiply into output reg.
// ----------------------------------------------------------------------------
module tmf_back #(
	parameter int CHANNELS    = tmf_pkg::CHANNELS_DEF,
	parameter int WINDOW      = tmf_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = tmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  tmf_pkg::tmf_in_t  pop_data,
	output logic              pop,
	output logic              avg_valid,
	input  logic              avg_stall,
	output tmf_pkg::tmf_out_t avg_data
);
	import tmf_pkg::*;

	localparam int SB      = SAMPLE_BITS;
	localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int SUM_W   = $clog2(WINDOW * ((2 ** SB) - 1) + 1);
	localparam int DIV     = WINDOW - 2;
	localparam int DIV_LOG = $clog2(DIV);
	localparam int SHIFT   = SUM_W + DIV_LOG;
	localparam int MUL_W   = SHIFT + 1;
	localparam int PROD_W  = SUM_W + MUL_W;
	localparam int QUOT_W  = PROD_W - SHIFT;
	// ceil(2^SHIFT / DIV): exact quotient for every SUM_W-bit dividend
	localparam logic [MUL_W-1:0] RECIP =
		MUL_W'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));
	localparam logic [SB-1:0] MIN_INIT = '1;

	// per-channel state
	logic [CNT_W-1:0] cnt_q [CHANNELS];
	logic [SUM_W-1:0] sum_q [CHANNELS];
	logic [SB-1:0]    min_q [CHANNELS];
	logic [SB-1:0]    max_q [CHANNELS];

	logic [IDX_W+CHAN_W-1:0] idx_wide;
	logic [IDX_W-1:0]        idx;
	logic [SB+SMP_W-1:0]     smp_wide;
	logic [SB-1:0]           smp;
	logic [CNT_W-1:0]        cnt_nxt;
	logic [SUM_W-1:0]        sum_nxt;
	logic [SB-1:0]           min_nxt;
	logic [SB-1:0]           max_nxt;
	logic                    done;

	// pipeline
	logic              vld_s1, vld_s2, vld_s3;
	logic [CHAN_W-1:0] ch_s1, ch_s2;
	logic [SUM_W-1:0]  sum_s1;
	logic [SB-1:0]     min_s1, max_s1;
	logic [SUM_W-1:0]  trim_s2;
	tmf_out_t          out_s3;
	logic              rdy_s1, rdy_s2, rdy_s3;

	logic [PROD_W-1:0]       prod;
	logic [QUOT_W-1:0]       quot;
	logic [QUOT_W+AVG_W-1:0] quot_wide;

	assign rdy_s3 = !vld_s3 || !avg_stall;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign pop    = !empty && rdy_s1;

	assign idx_wide = (IDX_W + CHAN_W)'(pop_data.channel);
	assign idx      = idx_wide[IDX_W-1:0];
	assign smp_wide = (SB + SMP_W)'(pop_data.sample);
	assign smp      = smp_wide[SB-1:0];

	always_comb begin
		cnt_nxt = cnt_q[idx] + 1'b1;
		sum_nxt = sum_q[idx] + SUM_W'(smp);
		min_nxt = (smp < min_q[idx]) ? smp : min_q[idx];
		max_nxt = (smp > max_q[idx]) ? smp : max_q[idx];
		done    = (cnt_nxt == CNT_W'(WINDOW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
				min_q[i] <= MIN_INIT;
				max_q[i] <= '0;
			end
		end else if (pop) begin
			if (done) begin
				// window complete: start the channel over
				cnt_q[idx] <= '0;
				sum_q[idx] <= '0;
				min_q[idx] <= MIN_INIT;
				max_q[idx] <= '0;
			end else begin
				cnt_q[idx] <= cnt_nxt;
				sum_q[idx] <= sum_nxt;
				min_q[idx] <= min_nxt;
				max_q[idx] <= max_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= pop && done;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	assign prod      = PROD_W'(trim_s2) * PROD_W'(RECIP);
	assign quot      = prod[PROD_W-1:SHIFT];
	assign quot_wide = (QUOT_W + AVG_W)'(quot);

	always_ff @(posedge clk) begin
		if (rdy_s1 && pop && done) begin
			ch_s1  <= pop_data.channel;
			sum_s1 <= sum_nxt;
			min_s1 <= min_nxt;
			max_s1 <= max_nxt;
		end
		if (rdy_s2 && vld_s1) begin
			ch_s2   <= ch_s1;
			trim_s2 <= sum_s1 - SUM_W'(min_s1) - SUM_W'(max_s1);
		end
		if (rdy_s3 && vld_s2) begin
			out_s3.out_channel <= ch_s2;
			out_s3.average     <= quot_wide[AVG_W-1:0];
		end
	end

	assign avg_valid = vld_s3;
	assign avg_data  = out_s3;

`ifndef SYNTHESIS
	a_cnt_below_window: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (32'(cnt_q[idx]) < WINDOW))
		else $error("channel count reached the window without a result");
	a_extremes_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (min_s1 <= max_s1))
		else $error("window minimum above its maximum");
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !rdy_s3) |=> (vld_s2 && $stable(trim_s2) && $stable(ch_s2)))
		else $error("trim stage changed while held");
`endif

endmodule

FILE: hdl/trimmed_mean_filter.sv
// ----------------------------------------------------------------------------
// trimmed_mean_filter
// Per-channel trimmed mean of ADC samples: over each window of WINDOW
// samples, emit (sum - min - max) / (WINDOW - 2) and restart the channel.
// ----------------------------------------------------------------------------
//  port group  | dir | payload    | notes
//  smp_*       | in  | tmf_in_t   | channel + sample, beats of absent
//              |     |            | channels are taken and dropped
//  avg_*       | out | tmf_out_t  | one beat per completed window
//
// Sustains one sample beat per cycle while avg_stall is low; the per-channel
// state update at the queue pop reads combinationally and writes at the pop,
// so same-channel beats may follow back to back. The path from sample to
// average: input reg, queue, accumulate, trim, multiply into output reg.
// Reset clears all channel state at once, no clearing pass.
// A stalled output fills the back pipeline, then the queue, then smp_stall.
// ----------------------------------------------------------------------------
module trimmed_mean_filter #(
	parameter int CHANNELS    = tmf_pkg::CHANNELS_DEF,
	parameter int WINDOW      = tmf_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = tmf_pkg::SAMPLE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              smp_valid,
	output logic              smp_stall,
	input  tmf_pkg::tmf_in_t  smp_data,
	output logic              avg_valid,
	input  logic              avg_stall,
	output tmf_pkg::tmf_out_t avg_data
);
	import tmf_pkg::*;

	logic    push, pop, full, empty;
	tmf_in_t push_data, pop_data;

	tmf_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_data  (smp_data),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	tmf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (full),
		.empty     (empty)
	);

	tmf_back #(
		.CHANNELS    (CHANNELS),
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_data  (pop_data),
		.pop       (pop),
		.avg_valid (avg_valid),
		.avg_stall (avg_stall),
		.avg_data  (avg_data)
	);

endmodule
